// ===== rtl/core/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants for the slip frame decoder: framing codes and field widths.
// ----------------------------------------------------------------------------
package sfd_pkg;

   // slip framing codes
   localparam logic [7:0] SLIP_END     = 8'hC0;
   localparam logic [7:0] SLIP_ESC     = 8'hDB;
   localparam logic [7:0] SLIP_ESC_END = 8'hDC;
   localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

   // result field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned SLOT_W   = 3;
   localparam int unsigned OFFSET_W = 8;
   localparam int unsigned LENGTH_W = 9;

   typedef logic [BYTE_W-1:0] byte_type;

endpackage

// ===== rtl/core/slip_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// slip_frame_decoder
// Strips slip framing from a received byte stream and reports each stored
// byte with its buffer slot and offset, and each frame end with its length and overflow flag.
// ----------------------------------------------------------------------------
// a result is registered and shows on rsp_* in the cycle after its item is accepted
// throughput: one item per cycle; the single output register drains in the
//    same cycle it refills, so req_ready only drops while a result is stalled
// items that give no result (escape byte, dropped byte) are still accepted like any other
// reset is synchronous, active high: no escape pending, slot 1 active,
//    empty frame, no overflow, output register empty
module slip_frame_decoder
   import sfd_pkg::*;
#(
   parameter int unsigned NUM_SLOTS    = 5,
   parameter int unsigned BUFFER_BYTES = 256
) (
   input  logic                clock,
   input  logic                reset,
   // input channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BYTE_W-1:0]   req_rx_byte,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BYTE_W-1:0]   rsp_data_byte,
   output logic                rsp_frame_end,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [OFFSET_W-1:0] rsp_offset,
   output logic [LENGTH_W-1:0] rsp_frame_length,
   output logic                rsp_overflow
);

   // internal widths follow the parameters
   localparam int unsigned AS_W  = $clog2(NUM_SLOTS);
   localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);
   // widened copies so the result fields can always be part-selected
   localparam int unsigned AS_XW  = (AS_W > SLOT_W) ? AS_W : SLOT_W;
   localparam int unsigned CNT_XW = (CNT_W > LENGTH_W) ? CNT_W : LENGTH_W;

   localparam logic [AS_W-1:0]  SLOT_LAST  = AS_W'(NUM_SLOTS - 1);
   localparam logic [AS_W-1:0]  SLOT_RESET = AS_W'(1);
   localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(BUFFER_BYTES);

   // decoder state
   logic             escape_pending_ff, escape_pending_in;
   logic [AS_W-1:0]  active_slot_ff, active_slot_in;
   logic [CNT_W-1:0] write_count_ff, write_count_in;
   logic             frame_overflowed_ff, frame_overflowed_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   byte_type            data_byte_ff, data_byte_in;
   logic                frame_end_ff, frame_end_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   logic                overflow_ff, overflow_in;

   logic                accept;
   logic                emit;
   logic                is_end;
   logic                is_esc;
   logic                full;
   byte_type            decoded;
   logic [AS_XW-1:0]    slot_wide;
   logic [CNT_XW-1:0]   count_wide;

   // output register frees up whenever its result is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign is_end     = (req_rx_byte == SLIP_END);
   assign is_esc     = (req_rx_byte == SLIP_ESC);
   assign full       = (write_count_ff >= CNT_FULL);
   assign slot_wide  = AS_XW'(active_slot_ff);
   assign count_wide = CNT_XW'(write_count_ff);

   // escape translation
   always_comb begin
      decoded = req_rx_byte;
      if (escape_pending_ff) begin
         if (req_rx_byte == SLIP_ESC_END) begin
            decoded = SLIP_END;
         end else if (req_rx_byte == SLIP_ESC_ESC) begin
            decoded = SLIP_ESC;
         end
      end
   end

   // next state and result
   always_comb begin
      escape_pending_in   = escape_pending_ff;
      active_slot_in      = active_slot_ff;
      write_count_in      = write_count_ff;
      frame_overflowed_in = frame_overflowed_ff;
      emit                = 1'b0;
      data_byte_in        = data_byte_ff;
      frame_end_in        = frame_end_ff;
      slot_in             = slot_ff;
      offset_in           = offset_ff;
      length_in           = length_ff;
      overflow_in         = overflow_ff;

      if (accept) begin
         if (is_end) begin
            // frame end: report and move to the next slot in the ring
            emit                = 1'b1;
            data_byte_in        = '0;
            frame_end_in        = 1'b1;
            slot_in             = slot_wide[SLOT_W-1:0];
            offset_in           = '0;
            length_in           = count_wide[LENGTH_W-1:0];
            overflow_in         = frame_overflowed_ff;
            active_slot_in      = (active_slot_ff == SLOT_LAST) ? '0
                                                                 : active_slot_ff + 1'b1;
            write_count_in      = '0;
            frame_overflowed_in = 1'b0;
            escape_pending_in   = 1'b0;
         end else if (!escape_pending_ff && is_esc) begin
            escape_pending_in = 1'b1;
         end else begin
            escape_pending_in = 1'b0;
            if (full) begin
               // no room left, drop and remember
               frame_overflowed_in = 1'b1;
            end else begin
               emit           = 1'b1;
               data_byte_in   = decoded;
               frame_end_in   = 1'b0;
               slot_in        = slot_wide[SLOT_W-1:0];
               offset_in      = count_wide[OFFSET_W-1:0];
               length_in      = '0;
               overflow_in    = 1'b0;
               write_count_in = write_count_ff + 1'b1;
            end
         end
      end

      if (accept) begin
         rsp_valid_in = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         escape_pending_ff   <= 1'b0;
         active_slot_ff      <= SLOT_RESET;
         write_count_ff      <= '0;
         frame_overflowed_ff <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         escape_pending_ff   <= escape_pending_in;
         active_slot_ff      <= active_slot_in;
         write_count_ff      <= write_count_in;
         frame_overflowed_ff <= frame_overflowed_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      data_byte_ff <= data_byte_in;
      frame_end_ff <= frame_end_in;
      slot_ff      <= slot_in;
      offset_ff    <= offset_in;
      length_ff    <= length_in;
      overflow_ff  <= overflow_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_byte    = data_byte_ff;
   assign rsp_frame_end    = frame_end_ff;
   assign rsp_slot         = slot_ff;
   assign rsp_offset       = offset_ff;
   assign rsp_frame_length = length_ff;
   assign rsp_overflow     = overflow_ff;

   // checks
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      active_slot_ff <= SLOT_LAST)
      else $error("active slot out of range");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      write_count_ff <= CNT_FULL)
      else $error("write count beyond buffer size");

   a_end_reported: assert property (@(posedge clock) disable iff (reset)
      (accept && is_end) |=> (rsp_valid && rsp_frame_end))
      else $error("frame end item gave no frame end result");

   a_data_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_end) |-> (!rsp_overflow && rsp_frame_length == '0))
      else $error("stored byte carries frame end fields");

   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> (rsp_data_byte == '0 && rsp_offset == '0))
      else $error("frame end carries byte fields");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the slip frame decoder against its own decoder model. A table of
// short directed frames goes first, followed by random well-formed frames
// with some noise, a full and an overflowing frame, and a long result stall.
// ----------------------------------------------------------------------------
module tb;
   import sfd_pkg::*;

   localparam int unsigned NUM_SLOTS    = 5;
   localparam int unsigned BUFFER_BYTES = 256;
   localparam int          DRAIN_CYCLES = 4;        // covers the output register plus margin
   localparam int          STALL_CYCLES = 60;       // long receiver hold-off
   localparam longint      LIMIT_NS     = 5_000_000;

   // one result item as the block reports it
   typedef struct packed {
      logic [BYTE_W-1:0]   data_byte;
      logic                frame_end;
      logic [SLOT_W-1:0]   slot;
      logic [OFFSET_W-1:0] offset;
      logic [LENGTH_W-1:0] frame_length;
      logic                overflow;
   } slip_result_type;

   // one row of the directed table; want holds only where typed is set
   typedef struct {
      byte_type        rx;
      bit              typed;
      bit              gives;
      slip_result_type want;
   } slip_step_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_rx_byte;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [BYTE_W-1:0]   rsp_data_byte;
   logic                rsp_frame_end;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [OFFSET_W-1:0] rsp_offset;
   logic [LENGTH_W-1:0] rsp_frame_length;
   logic                rsp_overflow;

   // decoder model state
   bit                  esc_seen;
   logic [SLOT_W-1:0]   fill_slot;
   int unsigned         fill_count;
   bit                  dropped;

   slip_result_type     pending_results[$];
   slip_step_type       directed_steps[$];
   int                  fail_count;
   int                  items_sent;
   int                  send_idle_pct;
   int                  recv_idle_pct;
   int                  stall_request;
   int                  hold_left = 0;

   slip_frame_decoder #(
      .NUM_SLOTS    (NUM_SLOTS),
      .BUFFER_BYTES (BUFFER_BYTES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_slot         (rsp_slot),
      .rsp_offset       (rsp_offset),
      .rsp_frame_length (rsp_frame_length),
      .rsp_overflow     (rsp_overflow)
   );

   // 12 ns clock, first rising edge at 6 ns
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // decode one raw byte; returns 1 and fills r when a result is due
   function automatic bit decode_byte(input byte_type rx, output slip_result_type r);
      byte_type b;
      r = '0;
      // frame end always wins, a pending escape is thrown away
      if (rx == SLIP_END) begin
         r.frame_end    = 1'b1;
         r.slot         = fill_slot;
         r.frame_length = fill_count[LENGTH_W-1:0];
         r.overflow     = dropped;
         fill_slot      = (fill_slot == NUM_SLOTS - 1) ? '0 : fill_slot + 1'b1;
         fill_count     = 0;
         dropped        = 1'b0;
         esc_seen       = 1'b0;
         return 1'b1;
      end
      if (!esc_seen && rx == SLIP_ESC) begin
         esc_seen = 1'b1;
         return 1'b0;
      end
      b = rx;
      // escaped byte: two known codes map, anything else passes through
      if (esc_seen) begin
         if (rx == SLIP_ESC_END)
            b = SLIP_END;
         else if (rx == SLIP_ESC_ESC)
            b = SLIP_ESC;
         esc_seen = 1'b0;
      end
      // buffer full: byte is dropped and remembered for the frame end
      if (fill_count >= BUFFER_BYTES) begin
         dropped = 1'b1;
         return 1'b0;
      end
      r.data_byte = b;
      r.slot      = fill_slot;
      r.offset    = fill_count[OFFSET_W-1:0];
      fill_count++;
      return 1'b1;
   endfunction

   // directed rows with the result typed in
   function automatic void typed_step(input byte_type rx, input logic [BYTE_W-1:0] data,
                                      input logic fe, input logic [SLOT_W-1:0] slot,
                                      input logic [OFFSET_W-1:0] off,
                                      input logic [LENGTH_W-1:0] len, input logic ovf);
      slip_step_type s;
      s.rx    = rx;
      s.typed = 1'b1;
      s.gives = 1'b1;
      s.want  = '{data, fe, slot, off, len, ovf};
      directed_steps.push_back(s);
   endfunction

   // directed rows known to give no result
   function automatic void silent_step(input byte_type rx);
      slip_step_type s;
      s.rx    = rx;
      s.typed = 1'b1;
      s.gives = 1'b0;
      s.want  = '0;
      directed_steps.push_back(s);
   endfunction

   // directed rows left to the decoder model
   function automatic void open_step(input byte_type rx);
      slip_step_type s;
      s.rx    = rx;
      s.typed = 1'b0;
      s.gives = 1'b0;
      s.want  = '0;
      directed_steps.push_back(s);
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // offer one item, hold it until accepted, then queue what it should give
   task automatic send_byte(input byte_type rx, input bit typed, input bit gives,
                            input slip_result_type want);
      slip_result_type r;
      bit              has;
      // random gap before the item, valid low meanwhile
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      // model state moves on for every item, typed rows included
      has = decode_byte(rx, r);
      if (typed) begin
         if (gives)
            pending_results.push_back(want);
      end else if (has) begin
         pending_results.push_back(r);
      end
   endtask

   task automatic send_open(input byte_type rx);
      send_byte(rx, 1'b0, 1'b0, '0);
   endtask

   // one frame of len decoded bytes, mostly encoded properly
   task automatic send_frame(input int len, input int noise_pct);
      byte_type v;
      for (int k = 0; k < len; k++) begin
         // bias toward the framing codes
         if ($urandom_range(99) < 12) begin
            case ($urandom_range(3))
               0: v = SLIP_END;
               1: v = SLIP_ESC;
               2: v = SLIP_ESC_END;
               default: v = SLIP_ESC_ESC;
            endcase
         end else begin
            v = byte_type'($urandom_range(255));
         end
         if ($urandom_range(99) < noise_pct) begin
            // broken encoding: byte sent raw, maybe behind a stray escape
            if ($urandom_range(1))
               send_open(SLIP_ESC);
            send_open(v);
         end else if (v == SLIP_END) begin
            send_open(SLIP_ESC);
            send_open(SLIP_ESC_END);
         end else if (v == SLIP_ESC) begin
            send_open(SLIP_ESC);
            send_open(SLIP_ESC_ESC);
         end else begin
            send_open(v);
         end
      end
      // now and then an escape right before the end
      if ($urandom_range(99) < 5)
         send_open(SLIP_ESC);
      send_open(SLIP_END);
   endtask

   // random frames until target items have gone in
   task automatic run_frames(input int target);
      while (items_sent < target) begin
         if ($urandom_range(99) < 10)
            send_frame($urandom_range(40), 10);
         else
            send_frame($urandom_range(12), 10);
      end
   endtask

   // sender pause: nothing offered until every expected result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result side: random ready, long hold-off on request, in-order checks
   always @(posedge clock) begin : rsp_side
      slip_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result item with no expectation waiting");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("data_byte", want.data_byte, rsp_data_byte);
               check_field("frame_end", want.frame_end, rsp_frame_end);
               check_field("slot", want.slot, rsp_slot);
               check_field("offset", want.offset, rsp_offset);
               check_field("frame_length", want.frame_length, rsp_frame_length);
               check_field("overflow", want.overflow, rsp_overflow);
            end
         end
         // a hold-off is counted down here, not in the stimulus
         if (stall_request > 0) begin
            hold_left     = stall_request;
            stall_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // hard stop in case the block hangs
   initial begin
      #(LIMIT_NS);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      // known values on every input from time zero
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_rx_byte   = '0;
      fail_count    = 0;
      items_sent    = 0;
      stall_request = 0;
      send_idle_pct = 11;
      recv_idle_pct = 84;
      // model state as after reset: slot 1 active, nothing stored
      esc_seen      = 1'b0;
      fill_slot     = SLOT_W'(1 % NUM_SLOTS);
      fill_count    = 0;
      dropped       = 1'b0;

      // directed frames, slot 1 first
      typed_step(SLIP_END, 8'h00, 1'b1, 3'd1, 8'd0, 9'd0, 1'b0);     // empty frame
      typed_step(8'h00, 8'h00, 1'b0, 3'd2, 8'd0, 9'd0, 1'b0);
      typed_step(8'hFF, 8'hFF, 1'b0, 3'd2, 8'd1, 9'd0, 1'b0);
      silent_step(SLIP_ESC);
      typed_step(SLIP_ESC_END, SLIP_END, 1'b0, 3'd2, 8'd2, 9'd0, 1'b0);
      silent_step(SLIP_ESC);
      typed_step(SLIP_ESC_ESC, SLIP_ESC, 1'b0, 3'd2, 8'd3, 9'd0, 1'b0);
      silent_step(SLIP_ESC);
      typed_step(SLIP_ESC, SLIP_ESC, 1'b0, 3'd2, 8'd4, 9'd0, 1'b0);  // escape after escape
      silent_step(SLIP_ESC);
      typed_step(8'h41, 8'h41, 1'b0, 3'd2, 8'd5, 9'd0, 1'b0);        // unknown escape
      silent_step(SLIP_ESC);
      typed_step(SLIP_END, 8'h00, 1'b1, 3'd2, 8'd0, 9'd6, 1'b0);     // end while escaped
      // escape partners without an escape are plain data
      open_step(SLIP_ESC_END);
      open_step(SLIP_ESC_ESC);
      open_step(8'h7F);
      open_step(8'h80);
      open_step(SLIP_END);
      open_step(SLIP_END);
      // slot wraps back to 0
      open_step(8'h55);
      open_step(8'hAA);
      open_step(SLIP_END);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i])
         send_byte(directed_steps[i].rx, directed_steps[i].typed, directed_steps[i].gives,
                   directed_steps[i].want);
      wait_drained();

      // sender mostly busy, receiver mostly idle
      run_frames(items_sent + 400);
      wait_drained();

      // sender mostly idle, receiver mostly ready; one exactly full frame
      send_idle_pct = 84;
      recv_idle_pct = 11;
      send_frame(BUFFER_BYTES, 0);
      run_frames(items_sent + 150);
      wait_drained();

      // no idling; long result stall while an overflowing frame keeps coming
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_request = STALL_CYCLES;
      send_frame(BUFFER_BYTES + 12, 0);
      run_frames(items_sent + 230);
      wait_drained();

      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
